@@ hw/rtl/b64sc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types and character mapping functions for the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int MaxRes   = 4;
  localparam int ResCntW  = $clog2(MaxRes + 1);
  localparam int ResIdxW  = $clog2(MaxRes);

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef struct packed {
    logic [23:0] acc;
    logic [1:0]  pos;
    logic [23:0] held;
    logic        held_valid;
    logic [1:0]  held_sent;
    logic [1:0]  pad_count;
    logic        pad_seen;
    logic        pad_closed;
  } b64sc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } b64sc_res_t;

  // six-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // character to six-bit value; bit 6 set when outside the alphabet
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end else begin
      r = 7'h40;
    end
    return r;
  endfunction

  function automatic logic [7:0] held_byte(input logic [23:0] h, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = h[23:16];
      2'd1:    b = h[15:8];
      default: b = h[7:0];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/b64sc_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_step
// Single-pass step logic: one item and the stream state in, up to four
// results and the next stream state out.
// ----------------------------------------------------------------------------
module b64sc_step import b64sc_pkg::*; (
  input  wire logic                      mode,
  input  wire b64sc_state_t              st,
  input  wire logic [7:0]                data,
  input  wire logic                      last,
  output b64sc_state_t                   nxt,
  output b64sc_res_t [MaxRes-1:0]        res,
  output logic [ResCntW-1:0]             res_n
);

  logic [2:0]         pos3;
  logic [23:0]        acc_e;
  logic [23:0]        grp;
  logic [6:0]         dv;
  logic               took;
  logic               nonpad;
  logic [1:0]         total;
  logic [ResCntW-1:0] n;

  always_comb begin
    nxt   = st;
    res   = '0;
    n     = '0;
    pos3  = {1'b0, st.pos} + 3'd1;
    acc_e = {st.acc[15:0], data};
    grp   = acc_e;
    dv    = dec_char(data);
    took  = 1'b0;
    nonpad = 1'b0;
    total = 2'd0;

    if (mode == MODE_ENCODE) begin
      if (pos3 < 3'd3 && !last) begin
        nxt.acc = acc_e;
        nxt.pos = pos3[1:0];
      end else begin
        case (pos3)
          3'd1:    grp = {acc_e[7:0], 16'h0};
          3'd2:    grp = {acc_e[15:0], 8'h0};
          default: grp = acc_e;
        endcase
        res[0] = '{data: enc_char(grp[23:18]), valid: 1'b1, last: 1'b0};
        res[1] = '{data: enc_char(grp[17:12]), valid: 1'b1, last: 1'b0};
        res[2] = '{data: (pos3 >= 3'd2) ? enc_char(grp[11:6]) : CHAR_PAD,
                   valid: 1'b1, last: 1'b0};
        res[3] = '{data: (pos3 >= 3'd3) ? enc_char(grp[5:0]) : CHAR_PAD,
                   valid: 1'b1, last: last};
        n = ResCntW'(MaxRes);
        nxt.acc = '0;
        nxt.pos = '0;
        if (last) begin
          nxt = '0;
        end
      end
    end else begin
      if (!st.pad_closed) begin
        if (data == CHAR_PAD) begin
          if (st.pad_count < 2'd3) begin
            nxt.pad_count = st.pad_count + 2'd1;
            nxt.pad_seen  = 1'b1;
            nxt.acc       = {st.acc[17:0], 6'd0};
            took          = 1'b1;
          end
        end else if (st.pad_seen) begin
          nxt.pad_closed = 1'b1;
        end else begin
          // characters outside the alphabet take a position only
          if (!dv[6]) begin
            nxt.acc = {st.acc[17:0], dv[5:0]};
          end
          took   = 1'b1;
          nonpad = 1'b1;
        end
      end

      if (took) begin
        if (pos3 == 3'd4) begin
          for (int k = 0; k < 3; k++) begin
            if (st.held_valid && 2'(k) >= st.held_sent && n < ResCntW'(MaxRes)) begin
              res[n[ResIdxW-1:0]] = '{data: held_byte(st.held, 2'(k)), valid: 1'b1,
                                      last: 1'b0};
              n = n + 1'b1;
            end
          end
          nxt.held       = nxt.acc;
          nxt.held_valid = 1'b1;
          nxt.held_sent  = '0;
          nxt.acc        = '0;
          nxt.pos        = '0;
        end else begin
          nxt.pos = pos3[1:0];
          // a held quartet owes one byte per following data character
          if (nonpad && st.held_valid && st.held_sent < 2'd3) begin
            res[0] = '{data: held_byte(st.held, st.held_sent), valid: 1'b1, last: 1'b0};
            n = ResCntW'(1);
            nxt.held_sent = st.held_sent + 2'd1;
          end
        end
      end

      if (last) begin
        total = nxt.held_valid ? 2'd3 - nxt.pad_count : 2'd0;
        if (total > nxt.held_sent) begin
          for (int k = 0; k < 3; k++) begin
            if (2'(k) >= nxt.held_sent && 2'(k) < total && n < ResCntW'(MaxRes)) begin
              res[n[ResIdxW-1:0]] = '{data: held_byte(nxt.held, 2'(k)), valid: 1'b1,
                                      last: (2'(k) + 2'd1 == total)};
              n = n + 1'b1;
            end
          end
        end else if (n < ResCntW'(MaxRes)) begin
          res[n[ResIdxW-1:0]] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
          n = n + 1'b1;
        end
        nxt = '0;
      end
    end
    res_n = n;
  end

endmodule
`default_nettype wire

@@ hw/rtl/b64sc_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_outq
// Result register bank: takes a burst of up to four results from one step
// and hands them out one transfer per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module b64sc_outq import b64sc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire b64sc_res_t [MaxRes-1:0]   load_res,
  input  wire logic [ResCntW-1:0]        load_n,
  output logic                           can_load,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_valid,
  output logic                           out_last
);

  b64sc_res_t [MaxRes-1:0] slots;
  logic [ResIdxW-1:0]      rd;
  logic [ResCntW-1:0]      cnt;
  logic                    pop;

  assign res_valid = (cnt != '0);
  assign pop       = res_valid && res_ready;
  assign can_load  = (cnt == '0) || (cnt == ResCntW'(1) && pop);

  assign out_byte  = slots[rd].data;
  assign out_valid = slots[rd].valid;
  assign out_last  = slots[rd].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (load) begin
      cnt <= load_n;
      rd  <= '0;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
      rd  <= rd + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_res;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= ResCntW'(MaxRes))
    else $error("result count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == '0) || (cnt == ResCntW'(1) && pop))
    else $error("results loaded over pending ones");

  a_last_final: assert property (@(posedge clk) disable iff (rst)
    pop && out_last |-> cnt == ResCntW'(1))
    else $error("end of message not the final buffered result");

endmodule
`default_nettype wire

@@ hw/rtl/base64_stream_codec_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec_core
// Base64 encoder/decoder on a byte stream, direction picked by the mode
// register.
// ----------------------------------------------------------------------------
// path: an accepted item is registered, then its step results load the result bank
// throughput: one item per cycle when it yields at most one result and res_ready
// stays high; an item yielding n results occupies the single result port for n
// transfers (encode: 4 characters per 3 bytes)
// reset: mode returns to encode, all stream state and pending results clear
module base64_stream_codec_core import b64sc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_in,
  input  wire logic       last_item,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_last
);

  logic                    mode;
  b64sc_state_t            st;
  b64sc_state_t            st_next;
  logic                    item_valid;
  logic [7:0]              item_data;
  logic                    item_last;
  logic                    fire;
  logic                    can_load;
  b64sc_res_t [MaxRes-1:0] step_res;
  logic [ResCntW-1:0]      step_n;

  assign cfg_ready = 1'b1;
  assign fire      = item_valid && can_load;
  assign in_ready  = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_data <= data_in;
      item_last <= last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
      st   <= '0;
    end else if (cfg_valid) begin
      mode <= cfg_data;
      st   <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  b64sc_step u_step (
    .mode  (mode),
    .st    (st),
    .data  (item_data),
    .last  (item_last),
    .nxt   (st_next),
    .res   (step_res),
    .res_n (step_n)
  );

  b64sc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_res  (step_res),
    .load_n    (step_n),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire
